FILE: rtl/vgfm_pkg.sv
`default_nettype none
package vgfm_pkg;

    localparam int EDGE_BITS = 4;
    localparam int CELL_BITS = 3 * EDGE_BITS;
    localparam int EPOCH_BITS = 8;
    localparam int VOX_BITS = 9;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [2:0] FACE_NX = 3'd0;
    localparam logic [2:0] FACE_PX = 3'd1;
    localparam logic [2:0] FACE_NY = 3'd2;
    localparam logic [2:0] FACE_PY = 3'd3;
    localparam logic [2:0] FACE_NZ = 3'd4;
    localparam logic [2:0] FACE_PZ = 3'd5;

    localparam logic [9:0] NRM_NEG  = 10'd0;
    localparam logic [9:0] NRM_ZERO = 10'd512;
    localparam logic [9:0] NRM_POS  = 10'h3FF;

    typedef logic [CELL_BITS-1:0] t_cell;

    function automatic logic [29:0] face_normal(input logic [2:0] f);
        logic [29:0] n;
        n = {NRM_ZERO, NRM_ZERO, NRM_ZERO};
        unique case (f)
            FACE_NX: n[9:0]   = NRM_NEG;
            FACE_PX: n[9:0]   = NRM_POS;
            FACE_NY: n[19:10] = NRM_NEG;
            FACE_PY: n[19:10] = NRM_POS;
            FACE_NZ: n[29:20] = NRM_NEG;
            FACE_PZ: n[29:20] = NRM_POS;
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic logic is_solid(input logic [VOX_BITS-1:0] v);
        return (v[7:0] != 8'd0) && !v[8];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/vgfm_if.sv
`default_nettype none
interface vgfm_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] voxel_type;
    logic       model_flag;

    modport source (output valid, func, pos_x, pos_y, pos_z, voxel_type, model_flag,
                    input ready);
    modport sink (input valid, func, pos_x, pos_y, pos_z, voxel_type, model_flag,
                  output ready);
endinterface

interface vgfm_out_if;
    logic        valid;
    logic        ready;
    logic        quad_valid;
    logic        mesh_done;
    logic [4:0]  corner_x;
    logic [4:0]  corner_y;
    logic [4:0]  corner_z;
    logic [4:0]  quad_width;
    logic [4:0]  quad_height;
    logic [7:0]  block_type;
    logic [2:0]  face_dir;
    logic [29:0] packed_normal;
    logic [31:0] island_tag;

    modport source (output valid, quad_valid, mesh_done, corner_x, corner_y, corner_z,
                    quad_width, quad_height, block_type, face_dir, packed_normal,
                    island_tag, input ready);
    modport sink (input valid, quad_valid, mesh_done, corner_x, corner_y, corner_z,
                  quad_width, quad_height, block_type, face_dir, packed_normal,
                  island_tag, output ready);
endinterface
`default_nettype wire

FILE: rtl/voxel_greedy_face_mesher.sv
// greedy face mesher over a 16x16x16 voxel chunk
// i_req (valid/ready): func 0 writes a voxel and restarts the meshing pass,
//   func 1 fetches the next merged quad, or a done beat once all six faces
//   are finished. a write gives no result beat, a fetch gives exactly one.
// o_quad (valid/ready): one result beat per fetch, held in an output register.
// i_cfg_we/i_cfg_data: island_id, copied into every quad; write only while idle.
// steps: a fetch is accepted, then each scanned cell passes the scan, probe and
//   evaluate states, each cell probed while widening and growing passes probe
//   and evaluate, the w*h cells of the quad are marked, a face change takes a
//   scan state, and the beat is emitted; one shared probe path over a two-port
//   voxel memory serves all of these. a full pass scans 6*4096 cells.
// the visited mask is an epoch-tagged memory; every 255 face changes or
//   restarts it is swept over all 4096 cells before work continues.
// reset: a clearing sweep over all 4096 cells zeroes the voxel store and the
//   visited tags; i_req.ready stays low until it ends.
// stall: a finished beat waits in the output register; the next fetch can
//   be accepted, but its own beat waits until the previous one is taken.
`default_nettype none
module voxel_greedy_face_mesher
    import vgfm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    vgfm_in_if.sink          i_req,
    vgfm_out_if.source       o_quad
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_PRB  = 4'd3;
    localparam logic [3:0] S_EV   = 4'd4;
    localparam logic [3:0] S_MARK = 4'd5;
    localparam logic [3:0] S_EMIT = 4'd6;
    localparam logic [3:0] S_VCLR = 4'd7;

    localparam logic [1:0] M_START = 2'd0;
    localparam logic [1:0] M_WIDE  = 2'd1;
    localparam logic [1:0] M_GROW  = 2'd2;

    logic [3:0]            r_state;
    logic [1:0]            r_mode;
    logic [CELL_BITS:0]    r_scan;
    logic [2:0]            r_face;
    logic                  r_done;
    logic                  r_emit_done;
    logic                  r_ret_scan;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [CELL_BITS-1:0]  r_clr;
    logic [31:0]           r_island;
    logic [CELL_BITS-1:0]  r_p;
    logic [4:0]            r_a;
    logic [4:0]            r_b;
    logic [4:0]            r_w;
    logic [4:0]            r_h;
    logic [7:0]            r_type;
    logic                  r_qin;
    logic                  r_nout;

    logic                  r_ov;
    logic                  r_o_qv;
    logic                  r_o_done;
    logic [4:0]            r_o_cx, r_o_cy, r_o_cz, r_o_w, r_o_h;
    logic [7:0]            r_o_type;
    logic [2:0]            r_o_face;
    logic [29:0]           r_o_nrm;
    logic [31:0]           r_o_tag;

    logic [4:0] px, py, pz, qx, qy, qz;
    logic       wa_x, wa_z, ha_y, ha_z;
    logic       q_in, n_out;
    t_cell      q_idx, nb_idx;
    logic [3:0] nx, ny, nz;

    logic                  st_we;
    t_cell                 st_waddr;
    logic [VOX_BITS-1:0]   st_wdata;
    logic [VOX_BITS-1:0]   st_rd_q, st_rd_n;
    logic                  vt_we;
    t_cell                 vt_waddr;
    logic [EPOCH_BITS-1:0] vt_wdata;
    logic [EPOCH_BITS-1:0] vt_rd;
    logic [EPOCH_BITS-1:0] vt_unused;

    logic accept, probe_ok, out_free;
    logic [EPOCH_BITS-1:0] epoch_inc;

    // probe coordinate: scan origin plus a along the width axis, b along height
    always_comb begin
        px = {1'b0, r_p[3:0]};
        py = {1'b0, r_p[7:4]};
        pz = {1'b0, r_p[11:8]};
        wa_z = (r_face == FACE_NX) || (r_face == FACE_PX);
        wa_x = !wa_z;
        ha_z = (r_face == FACE_NY) || (r_face == FACE_PY);
        ha_y = !ha_z;
        qx = px + (wa_x ? r_a : 5'd0);
        qy = py + (ha_y ? r_b : 5'd0);
        qz = pz + (wa_z ? r_a : 5'd0) + (ha_z ? r_b : 5'd0);
        q_in = !qx[4] && !qy[4] && !qz[4];
        q_idx = {qz[3:0], qy[3:0], qx[3:0]};
        nx = qx[3:0];
        ny = qy[3:0];
        nz = qz[3:0];
        n_out = 1'b0;
        unique case (r_face)
            FACE_NX: begin n_out = (qx[3:0] == 4'd0);  nx = qx[3:0] - 4'd1; end
            FACE_PX: begin n_out = (qx[3:0] == 4'd15); nx = qx[3:0] + 4'd1; end
            FACE_NY: begin n_out = (qy[3:0] == 4'd0);  ny = qy[3:0] - 4'd1; end
            FACE_PY: begin n_out = (qy[3:0] == 4'd15); ny = qy[3:0] + 4'd1; end
            FACE_NZ: begin n_out = (qz[3:0] == 4'd0);  nz = qz[3:0] - 4'd1; end
            default: begin n_out = (qz[3:0] == 4'd15); nz = qz[3:0] + 4'd1; end
        endcase
        nb_idx = {nz, ny, nx};
    end

    assign accept    = i_req.valid && i_req.ready;
    assign out_free  = !r_ov || o_quad.ready;
    assign epoch_inc = r_epoch + EPOCH_BITS'(1);
    assign probe_ok  = r_qin && is_solid(st_rd_q) && (r_nout || !is_solid(st_rd_n)) &&
                       (vt_rd != r_epoch) && ((r_mode == M_START) || (st_rd_q[7:0] == r_type));

    always_comb begin
        st_we    = 1'b0;
        st_waddr = {i_req.pos_z, i_req.pos_y, i_req.pos_x};
        st_wdata = {i_req.model_flag, i_req.voxel_type};
        vt_we    = 1'b0;
        vt_waddr = q_idx;
        vt_wdata = r_epoch;
        if (r_state == S_CLR) begin
            st_we    = 1'b1;
            st_waddr = r_clr;
            st_wdata = '0;
        end else if (r_state == S_IDLE && accept && i_req.func == FUNC_WRITE) begin
            st_we = 1'b1;
        end
        if (r_state == S_CLR || r_state == S_VCLR) begin
            vt_we    = 1'b1;
            vt_waddr = r_clr;
            vt_wdata = '0;
        end else if (r_state == S_MARK) begin
            vt_we = 1'b1;
        end
    end

    vgfm_ram #(.WIDTH(VOX_BITS), .DEPTH(1 << CELL_BITS)) u_store (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_waddr   (st_waddr),
        .i_wdata   (st_wdata),
        .i_raddr_a (q_idx),
        .i_raddr_b (nb_idx),
        .o_rdata_a (st_rd_q),
        .o_rdata_b (st_rd_n)
    );

    vgfm_ram #(.WIDTH(EPOCH_BITS), .DEPTH(1 << CELL_BITS)) u_visited (
        .i_clk     (i_clk),
        .i_we      (vt_we),
        .i_waddr   (vt_waddr),
        .i_wdata   (vt_wdata),
        .i_raddr_a (q_idx),
        .i_raddr_b (q_idx),
        .o_rdata_a (vt_rd),
        .o_rdata_b (vt_unused)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_mode      <= M_START;
            r_scan      <= '0;
            r_face      <= FACE_NX;
            r_done      <= 1'b0;
            r_emit_done <= 1'b0;
            r_ret_scan  <= 1'b0;
            r_epoch     <= EPOCH_BITS'(1);
            r_clr       <= '0;
            r_island    <= '0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_island <= i_cfg_data;
            end
            if (r_ov && o_quad.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR, S_VCLR: begin
                    r_clr <= r_clr + CELL_BITS'(1);
                    if (r_clr == {CELL_BITS{1'b1}}) begin
                        r_epoch <= EPOCH_BITS'(1);
                        r_state <= (r_state == S_VCLR && r_ret_scan) ? S_SCAN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.func == FUNC_WRITE) begin
                            r_scan <= '0;
                            r_face <= FACE_NX;
                            r_done <= 1'b0;
                            r_epoch <= epoch_inc;
                            if (epoch_inc == '0) begin
                                r_ret_scan <= 1'b0;
                                r_state    <= S_VCLR;
                            end
                        end else if (r_done) begin
                            r_emit_done <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan[CELL_BITS]) begin
                        // face finished: fresh visited epoch and next face, or done after the last face
                        r_scan  <= '0;
                        r_face  <= r_face + 3'd1;
                        if (r_face == FACE_PZ) begin
                            r_done      <= 1'b1;
                            r_emit_done <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_epoch <= epoch_inc;
                            if (epoch_inc == '0) begin
                                r_ret_scan <= 1'b1;
                                r_state    <= S_VCLR;
                            end
                        end
                    end else begin
                        r_p     <= r_scan[CELL_BITS-1:0];
                        r_scan  <= r_scan + (CELL_BITS+1)'(1);
                        r_a     <= '0;
                        r_b     <= '0;
                        r_mode  <= M_START;
                        r_state <= S_PRB;
                    end
                end
                S_PRB: begin
                    r_qin   <= q_in;
                    r_nout  <= n_out;
                    r_state <= S_EV;
                end
                S_EV: begin
                    r_state <= S_PRB;
                    unique case (r_mode)
                        M_START: begin
                            if (probe_ok) begin
                                r_type <= st_rd_q[7:0];
                                r_mode <= M_WIDE;
                                r_a    <= 5'd1;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        M_WIDE: begin
                            if (probe_ok) begin
                                r_a <= r_a + 5'd1;
                            end else begin
                                r_w    <= r_a;
                                r_a    <= '0;
                                r_b    <= 5'd1;
                                r_mode <= M_GROW;
                            end
                        end
                        default: begin
                            if (probe_ok) begin
                                if (r_a + 5'd1 == r_w) begin
                                    r_a <= '0;
                                    r_b <= r_b + 5'd1;
                                end else begin
                                    r_a <= r_a + 5'd1;
                                end
                            end else begin
                                r_h     <= r_b;
                                r_a     <= '0;
                                r_b     <= '0;
                                r_state <= S_MARK;
                            end
                        end
                    endcase
                end
                S_MARK: begin
                    if (r_a + 5'd1 == r_w) begin
                        r_a <= '0;
                        r_b <= r_b + 5'd1;
                        if (r_b + 5'd1 == r_h) begin
                            r_emit_done <= 1'b0;
                            r_state     <= S_EMIT;
                        end
                    end else begin
                        r_a <= r_a + 5'd1;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_emit_done <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            if (r_emit_done) begin
                r_o_qv   <= 1'b0;
                r_o_done <= 1'b1;
                r_o_cx   <= '0;
                r_o_cy   <= '0;
                r_o_cz   <= '0;
                r_o_w    <= '0;
                r_o_h    <= '0;
                r_o_type <= '0;
                r_o_face <= '0;
                r_o_nrm  <= '0;
                r_o_tag  <= '0;
            end else begin
                r_o_qv   <= 1'b1;
                r_o_done <= 1'b0;
                r_o_cx   <= px;
                r_o_cy   <= py;
                r_o_cz   <= pz;
                unique case (r_face)
                    FACE_PX: begin r_o_cx <= px + 5'd1; r_o_cz <= pz + r_w; end
                    FACE_PY: begin r_o_cy <= py + 5'd1; r_o_cz <= pz + r_h; end
                    FACE_NZ: r_o_cx <= px + r_w;
                    FACE_PZ: r_o_cz <= pz + 5'd1;
                    default: ;
                endcase
                r_o_w    <= r_w;
                r_o_h    <= r_h;
                r_o_type <= r_type;
                r_o_face <= r_face;
                r_o_nrm  <= face_normal(r_face);
                r_o_tag  <= r_island;
            end
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_quad.valid         = r_ov;
    assign o_quad.quad_valid    = r_o_qv;
    assign o_quad.mesh_done     = r_o_done;
    assign o_quad.corner_x      = r_o_cx;
    assign o_quad.corner_y      = r_o_cy;
    assign o_quad.corner_z      = r_o_cz;
    assign o_quad.quad_width    = r_o_w;
    assign o_quad.quad_height   = r_o_h;
    assign o_quad.block_type    = r_o_type;
    assign o_quad.face_dir      = r_o_face;
    assign o_quad.packed_normal = r_o_nrm;
    assign o_quad.island_tag    = r_o_tag;
endmodule
`default_nettype wire

FILE: rtl/vgfm_ram.sv
`default_nettype none
module vgfm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end
endmodule
`default_nettype wire
